@@ rtl/core/cpu65_pkg.sv @@
`timescale 1ns / 1ps

package cpu65_pkg;

    // Operation codes
    localparam logic [6:0] OP_ADC  = 7'd0;
    localparam logic [6:0] OP_SBC  = 7'd1;
    localparam logic [6:0] OP_AND  = 7'd2;
    localparam logic [6:0] OP_ORA  = 7'd3;
    localparam logic [6:0] OP_EOR  = 7'd4;
    localparam logic [6:0] OP_ASLA = 7'd5;
    localparam logic [6:0] OP_ASLM = 7'd6;
    localparam logic [6:0] OP_LSRA = 7'd7;
    localparam logic [6:0] OP_LSRM = 7'd8;
    localparam logic [6:0] OP_ROLA = 7'd9;
    localparam logic [6:0] OP_ROLM = 7'd10;
    localparam logic [6:0] OP_RORA = 7'd11;
    localparam logic [6:0] OP_RORM = 7'd12;
    localparam logic [6:0] OP_INC  = 7'd13;
    localparam logic [6:0] OP_DEC  = 7'd14;
    localparam logic [6:0] OP_INX  = 7'd15;
    localparam logic [6:0] OP_INY  = 7'd16;
    localparam logic [6:0] OP_DEX  = 7'd17;
    localparam logic [6:0] OP_DEY  = 7'd18;
    localparam logic [6:0] OP_CMP  = 7'd19;
    localparam logic [6:0] OP_CPX  = 7'd20;
    localparam logic [6:0] OP_CPY  = 7'd21;
    localparam logic [6:0] OP_BIT  = 7'd22;
    localparam logic [6:0] OP_LDA  = 7'd23;
    localparam logic [6:0] OP_LDX  = 7'd24;
    localparam logic [6:0] OP_LDY  = 7'd25;
    localparam logic [6:0] OP_STA  = 7'd26;
    localparam logic [6:0] OP_STX  = 7'd27;
    localparam logic [6:0] OP_STY  = 7'd28;
    localparam logic [6:0] OP_TAX  = 7'd29;
    localparam logic [6:0] OP_TAY  = 7'd30;
    localparam logic [6:0] OP_TXA  = 7'd31;
    localparam logic [6:0] OP_TYA  = 7'd32;
    localparam logic [6:0] OP_TSX  = 7'd33;
    localparam logic [6:0] OP_TXS  = 7'd34;
    localparam logic [6:0] OP_CLC  = 7'd35;
    localparam logic [6:0] OP_SEC  = 7'd36;
    localparam logic [6:0] OP_CLI  = 7'd37;
    localparam logic [6:0] OP_SEI  = 7'd38;
    localparam logic [6:0] OP_CLD  = 7'd39;
    localparam logic [6:0] OP_SED  = 7'd40;
    localparam logic [6:0] OP_CLV  = 7'd41;
    localparam logic [6:0] OP_BCC  = 7'd42;
    localparam logic [6:0] OP_BCS  = 7'd43;
    localparam logic [6:0] OP_BEQ  = 7'd44;
    localparam logic [6:0] OP_BNE  = 7'd45;
    localparam logic [6:0] OP_BMI  = 7'd46;
    localparam logic [6:0] OP_BPL  = 7'd47;
    localparam logic [6:0] OP_BVC  = 7'd48;
    localparam logic [6:0] OP_BVS  = 7'd49;
    localparam logic [6:0] OP_ALR  = 7'd50;
    localparam logic [6:0] OP_ANC  = 7'd51;
    localparam logic [6:0] OP_ARR  = 7'd52;
    localparam logic [6:0] OP_AXS  = 7'd53;
    localparam logic [6:0] OP_DCP  = 7'd54;
    localparam logic [6:0] OP_ISC  = 7'd55;
    localparam logic [6:0] OP_LAS  = 7'd56;
    localparam logic [6:0] OP_LAX  = 7'd57;
    localparam logic [6:0] OP_RLA  = 7'd58;
    localparam logic [6:0] OP_RRA  = 7'd59;
    localparam logic [6:0] OP_SLO  = 7'd60;
    localparam logic [6:0] OP_SRE  = 7'd61;
    localparam logic [6:0] OP_SAX  = 7'd62;
    localparam logic [6:0] OP_XAA  = 7'd63;

    // Status bit positions
    localparam int unsigned FLAG_C   = 0;
    localparam int unsigned FLAG_Z   = 1;
    localparam int unsigned FLAG_I   = 2;
    localparam int unsigned FLAG_D   = 3;
    localparam int unsigned FLAG_B   = 4;
    localparam int unsigned FLAG_ONE = 5;
    localparam int unsigned FLAG_V   = 6;
    localparam int unsigned FLAG_N   = 7;

    // Reset values
    localparam logic [7:0] SP_RESET     = 8'hFD;
    localparam logic [7:0] STATUS_RESET = 8'h24;

    // Architectural register file
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] s;
        logic [7:0] p;
    } regs_t;

endpackage

@@ rtl/core/cpu_6502_execute_unit.sv @@
`timescale 1ns / 1ps
// An input transfer loads the input register; one ALU pass then loads the result
// register. Throughput: one operation per cycle while out_stall is low; the register
// file is updated by the ALU in the same cycle that the result register loads, so
// dependent ops run back to back.
// Reset (rst_n low, asynchronous): A = X = Y = 0, S = 0xFD, status = 0x24,
// both pipeline stages empty.

module cpu_6502_execute_unit
    import cpu65_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [6:0] action,
    input  logic [7:0] operand,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] write_data,
    output logic       write_enable,
    output logic       branch_taken,
    output logic [7:0] acc_out,
    output logic [7:0] x_out,
    output logic [7:0] y_out,
    output logic [7:0] sp_out,
    output logic [7:0] status_out
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [6:0] s1_action_reg;
    logic [7:0] s1_operand_reg;
    regs_t      state_reg;
    regs_t      state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] wd_reg;
    logic       we_reg;
    logic       br_reg;
    regs_t      regs_out_reg;
    logic [7:0] alu_wd;
    logic       alu_we;
    logic       alu_br;
    logic       out_ready;
    logic       in_xfer;
    logic       advance;

    // Handshake control
    assign out_ready      = ~out_valid_reg | ~out_stall;
    assign advance        = s1_valid_reg & out_ready;
    assign in_stall       = s1_valid_reg & ~out_ready;
    assign in_xfer        = in_valid & ~in_stall;
    assign s1_valid_next  = in_xfer | (s1_valid_reg & ~out_ready);
    assign out_valid_next = advance | (out_valid_reg & out_stall);

    // ALU between input register and result register
    cpu65_alu u_alu (
        .action       (s1_action_reg),
        .operand      (s1_operand_reg),
        .regs_cur     (state_reg),
        .regs_nxt     (state_next),
        .write_data   (alu_wd),
        .write_enable (alu_we),
        .branch_taken (alu_br)
    );

    // Control and register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{a: 8'd0, x: 8'd0, y: 8'd0, s: SP_RESET, p: STATUS_RESET};
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_action_reg  <= action;
            s1_operand_reg <= operand;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            wd_reg       <= alu_wd;
            we_reg       <= alu_we;
            br_reg       <= alu_br;
            regs_out_reg <= state_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_data   = wd_reg;
    assign write_enable = we_reg;
    assign branch_taken = br_reg;
    assign acc_out      = regs_out_reg.a;
    assign x_out        = regs_out_reg.x;
    assign y_out        = regs_out_reg.y;
    assign sp_out       = regs_out_reg.s;
    assign status_out   = regs_out_reg.p;

endmodule

@@ rtl/core/cpu65_alu.sv @@
`timescale 1ns / 1ps

module cpu65_alu
    import cpu65_pkg::*;
(
    input  logic [6:0] action,
    input  logic [7:0] operand,
    input  regs_t      regs_cur,
    output regs_t      regs_nxt,
    output logic [7:0] write_data,
    output logic       write_enable,
    output logic       branch_taken
);

    localparam logic [1:0] SH_ASL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ROL = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // Shifter: returns {carry_out, result}
    function automatic logic [8:0] shift8(input logic [1:0] kind, input logic [7:0] v,
                                          input logic cin);
        logic [8:0] r;
        begin
            case (kind)
                SH_ASL:  r = {v[7], v[6:0], 1'b0};
                SH_LSR:  r = {v[0], 1'b0, v[7:1]};
                SH_ROL:  r = {v[7], v[6:0], cin};
                SH_ROR:  r = {v[0], cin, v[7:1]};
                default: r = {v[7], v[6:0], 1'b0};
            endcase
            return r;
        end
    endfunction

    logic       c_in;
    logic [7:0] and_av;
    logic [7:0] inc_v;
    logic [7:0] dec_v;
    logic [8:0] ror_v;
    logic [7:0] add_in;
    logic       add_cin;
    logic [8:0] sum;
    logic       add_ovf;
    logic [7:0] cmp_lhs;
    logic [7:0] cmp_rhs;
    logic [8:0] diff;
    logic [8:0] sh;
    logic [7:0] nz_val;
    logic       nz_en;

    assign c_in   = regs_cur.p[FLAG_C];
    assign and_av = regs_cur.a & operand;
    assign inc_v  = operand + 8'd1;
    assign dec_v  = operand - 8'd1;
    assign ror_v  = shift8(SH_ROR, operand, c_in);

    // Shared adder: ADC, SBC, ISC and RRA
    always_comb
    begin
        add_in  = operand;
        add_cin = c_in;
        case (action)
            OP_SBC:  add_in = ~operand;
            OP_ISC:  add_in = ~inc_v;
            OP_RRA:
            begin
                add_in  = ror_v[7:0];
                add_cin = ror_v[8];
            end
            default: add_in = operand;
        endcase
    end

    assign sum     = {1'b0, regs_cur.a} + {1'b0, add_in} + {8'd0, add_cin};
    assign add_ovf = ~(regs_cur.a[7] ^ add_in[7]) & (regs_cur.a[7] ^ sum[7]);

    // Shared comparator: CMP, CPX, CPY, DCP, AXS
    always_comb
    begin
        case (action)
            OP_CPX:  cmp_lhs = regs_cur.x;
            OP_CPY:  cmp_lhs = regs_cur.y;
            OP_AXS:  cmp_lhs = regs_cur.a & regs_cur.x;
            default: cmp_lhs = regs_cur.a;
        endcase
        cmp_rhs = (action == OP_DCP) ? dec_v : operand;
    end

    assign diff = {1'b0, cmp_lhs} - {1'b0, cmp_rhs};

    // Operation decode and register update
    always_comb
    begin
        regs_nxt     = regs_cur;
        write_data   = 8'd0;
        write_enable = 1'b0;
        branch_taken = 1'b0;
        nz_val       = 8'd0;
        nz_en        = 1'b0;
        sh           = 9'd0;

        case (action)
            OP_ADC, OP_SBC:
            begin
                regs_nxt.a         = sum[7:0];
                regs_nxt.p[FLAG_C] = sum[8];
                regs_nxt.p[FLAG_V] = add_ovf;
                nz_val = sum[7:0];
                nz_en  = 1'b1;
            end
            OP_AND:
            begin
                regs_nxt.a = and_av;
                nz_val = and_av;
                nz_en  = 1'b1;
            end
            OP_ORA:
            begin
                regs_nxt.a = regs_cur.a | operand;
                nz_val = regs_cur.a | operand;
                nz_en  = 1'b1;
            end
            OP_EOR:
            begin
                regs_nxt.a = regs_cur.a ^ operand;
                nz_val = regs_cur.a ^ operand;
                nz_en  = 1'b1;
            end
            OP_ASLA, OP_LSRA, OP_ROLA, OP_RORA:
            begin
                case (action)
                    OP_ASLA: sh = shift8(SH_ASL, regs_cur.a, c_in);
                    OP_LSRA: sh = shift8(SH_LSR, regs_cur.a, c_in);
                    OP_ROLA: sh = shift8(SH_ROL, regs_cur.a, c_in);
                    default: sh = shift8(SH_ROR, regs_cur.a, c_in);
                endcase
                regs_nxt.a         = sh[7:0];
                regs_nxt.p[FLAG_C] = sh[8];
                nz_val = sh[7:0];
                nz_en  = 1'b1;
            end
            OP_ASLM, OP_LSRM, OP_ROLM, OP_RORM:
            begin
                case (action)
                    OP_ASLM: sh = shift8(SH_ASL, operand, c_in);
                    OP_LSRM: sh = shift8(SH_LSR, operand, c_in);
                    OP_ROLM: sh = shift8(SH_ROL, operand, c_in);
                    default: sh = shift8(SH_ROR, operand, c_in);
                endcase
                write_data         = sh[7:0];
                write_enable       = 1'b1;
                regs_nxt.p[FLAG_C] = sh[8];
                nz_val = sh[7:0];
                nz_en  = 1'b1;
            end
            OP_INC:
            begin
                write_data   = inc_v;
                write_enable = 1'b1;
                nz_val = inc_v;
                nz_en  = 1'b1;
            end
            OP_DEC:
            begin
                write_data   = dec_v;
                write_enable = 1'b1;
                nz_val = dec_v;
                nz_en  = 1'b1;
            end
            OP_INX:
            begin
                regs_nxt.x = regs_cur.x + 8'd1;
                nz_val = regs_cur.x + 8'd1;
                nz_en  = 1'b1;
            end
            OP_INY:
            begin
                regs_nxt.y = regs_cur.y + 8'd1;
                nz_val = regs_cur.y + 8'd1;
                nz_en  = 1'b1;
            end
            OP_DEX:
            begin
                regs_nxt.x = regs_cur.x - 8'd1;
                nz_val = regs_cur.x - 8'd1;
                nz_en  = 1'b1;
            end
            OP_DEY:
            begin
                regs_nxt.y = regs_cur.y - 8'd1;
                nz_val = regs_cur.y - 8'd1;
                nz_en  = 1'b1;
            end
            OP_CMP, OP_CPX, OP_CPY:
            begin
                regs_nxt.p[FLAG_C] = ~diff[8];
                nz_val = diff[7:0];
                nz_en  = 1'b1;
            end
            OP_BIT:
            begin
                regs_nxt.p[FLAG_Z] = (and_av == 8'd0);
                regs_nxt.p[FLAG_N] = operand[7];
                regs_nxt.p[FLAG_V] = operand[6];
            end
            OP_LDA:
            begin
                regs_nxt.a = operand;
                nz_val = operand;
                nz_en  = 1'b1;
            end
            OP_LDX:
            begin
                regs_nxt.x = operand;
                nz_val = operand;
                nz_en  = 1'b1;
            end
            OP_LDY:
            begin
                regs_nxt.y = operand;
                nz_val = operand;
                nz_en  = 1'b1;
            end
            OP_STA:
            begin
                write_data   = regs_cur.a;
                write_enable = 1'b1;
            end
            OP_STX:
            begin
                write_data   = regs_cur.x;
                write_enable = 1'b1;
            end
            OP_STY:
            begin
                write_data   = regs_cur.y;
                write_enable = 1'b1;
            end
            OP_TAX:
            begin
                regs_nxt.x = regs_cur.a;
                nz_val = regs_cur.a;
                nz_en  = 1'b1;
            end
            OP_TAY:
            begin
                regs_nxt.y = regs_cur.a;
                nz_val = regs_cur.a;
                nz_en  = 1'b1;
            end
            OP_TXA:
            begin
                regs_nxt.a = regs_cur.x;
                nz_val = regs_cur.x;
                nz_en  = 1'b1;
            end
            OP_TYA:
            begin
                regs_nxt.a = regs_cur.y;
                nz_val = regs_cur.y;
                nz_en  = 1'b1;
            end
            OP_TSX:
            begin
                regs_nxt.x = regs_cur.s;
                nz_val = regs_cur.s;
                nz_en  = 1'b1;
            end
            OP_TXS: regs_nxt.s = regs_cur.x;
            OP_CLC: regs_nxt.p[FLAG_C] = 1'b0;
            OP_SEC: regs_nxt.p[FLAG_C] = 1'b1;
            OP_CLI: regs_nxt.p[FLAG_I] = 1'b0;
            OP_SEI: regs_nxt.p[FLAG_I] = 1'b1;
            OP_CLD: regs_nxt.p[FLAG_D] = 1'b0;
            OP_SED: regs_nxt.p[FLAG_D] = 1'b1;
            OP_CLV: regs_nxt.p[FLAG_V] = 1'b0;
            OP_BCC: branch_taken = ~regs_cur.p[FLAG_C];
            OP_BCS: branch_taken = regs_cur.p[FLAG_C];
            OP_BEQ: branch_taken = regs_cur.p[FLAG_Z];
            OP_BNE: branch_taken = ~regs_cur.p[FLAG_Z];
            OP_BMI: branch_taken = regs_cur.p[FLAG_N];
            OP_BPL: branch_taken = ~regs_cur.p[FLAG_N];
            OP_BVC: branch_taken = ~regs_cur.p[FLAG_V];
            OP_BVS: branch_taken = regs_cur.p[FLAG_V];
            OP_ALR:
            begin
                sh = shift8(SH_LSR, and_av, c_in);
                regs_nxt.a         = sh[7:0];
                regs_nxt.p[FLAG_C] = sh[8];
                nz_val = sh[7:0];
                nz_en  = 1'b1;
            end
            OP_ANC:
            begin
                regs_nxt.a         = and_av;
                regs_nxt.p[FLAG_C] = and_av[7];
                nz_val = and_av;
                nz_en  = 1'b1;
            end
            OP_ARR:
            begin
                sh = shift8(SH_ROR, and_av, c_in);
                regs_nxt.a         = sh[7:0];
                regs_nxt.p[FLAG_C] = sh[6];
                regs_nxt.p[FLAG_V] = sh[6] ^ sh[5];
                nz_val = sh[7:0];
                nz_en  = 1'b1;
            end
            OP_AXS:
            begin
                regs_nxt.x         = diff[7:0];
                regs_nxt.p[FLAG_C] = ~diff[8];
                nz_val = diff[7:0];
                nz_en  = 1'b1;
            end
            OP_DCP:
            begin
                write_data         = dec_v;
                write_enable       = 1'b1;
                regs_nxt.p[FLAG_C] = ~diff[8];
                nz_val = diff[7:0];
                nz_en  = 1'b1;
            end
            OP_ISC:
            begin
                write_data         = inc_v;
                write_enable       = 1'b1;
                regs_nxt.a         = sum[7:0];
                regs_nxt.p[FLAG_C] = sum[8];
                regs_nxt.p[FLAG_V] = add_ovf;
                nz_val = sum[7:0];
                nz_en  = 1'b1;
            end
            OP_LAS:
            begin
                regs_nxt.s = regs_cur.s & operand;
                regs_nxt.a = regs_cur.s & operand;
                regs_nxt.x = regs_cur.s & operand;
                nz_val = regs_cur.s & operand;
                nz_en  = 1'b1;
            end
            OP_LAX:
            begin
                regs_nxt.a = operand;
                regs_nxt.x = operand;
                nz_val = operand;
                nz_en  = 1'b1;
            end
            OP_RLA:
            begin
                sh = shift8(SH_ROL, operand, c_in);
                write_data         = sh[7:0];
                write_enable       = 1'b1;
                regs_nxt.a         = regs_cur.a & sh[7:0];
                regs_nxt.p[FLAG_C] = sh[8];
                nz_val = regs_cur.a & sh[7:0];
                nz_en  = 1'b1;
            end
            OP_RRA:
            begin
                // carry out of the rotate feeds the add
                write_data         = ror_v[7:0];
                write_enable       = 1'b1;
                regs_nxt.a         = sum[7:0];
                regs_nxt.p[FLAG_C] = sum[8];
                regs_nxt.p[FLAG_V] = add_ovf;
                nz_val = sum[7:0];
                nz_en  = 1'b1;
            end
            OP_SLO:
            begin
                sh = shift8(SH_ASL, operand, c_in);
                write_data         = sh[7:0];
                write_enable       = 1'b1;
                regs_nxt.a         = regs_cur.a | sh[7:0];
                regs_nxt.p[FLAG_C] = sh[8];
                nz_val = regs_cur.a | sh[7:0];
                nz_en  = 1'b1;
            end
            OP_SRE:
            begin
                sh = shift8(SH_LSR, operand, c_in);
                write_data         = sh[7:0];
                write_enable       = 1'b1;
                regs_nxt.a         = regs_cur.a ^ sh[7:0];
                regs_nxt.p[FLAG_C] = sh[8];
                nz_val = regs_cur.a ^ sh[7:0];
                nz_en  = 1'b1;
            end
            OP_SAX:
            begin
                write_data   = regs_cur.a & regs_cur.x;
                write_enable = 1'b1;
            end
            OP_XAA:
            begin
                regs_nxt.a = regs_cur.x & operand;
                nz_val = regs_cur.x & operand;
                nz_en  = 1'b1;
            end
            default: regs_nxt = regs_cur;
        endcase

        if (nz_en)
        begin
            regs_nxt.p[FLAG_N] = nz_val[7];
            regs_nxt.p[FLAG_Z] = (nz_val == 8'd0);
        end

        // fixed status bits
        regs_nxt.p[FLAG_ONE] = 1'b1;
        regs_nxt.p[FLAG_B]   = 1'b0;
    end

endmodule

@@ rtl/core/cpu65_checker.sv @@
`timescale 1ns / 1ps

module cpu65_checker
    import cpu65_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [6:0] action,
    input logic [7:0] operand,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] write_data,
    input logic       write_enable,
    input logic       branch_taken,
    input logic [7:0] acc_out,
    input logic [7:0] x_out,
    input logic [7:0] y_out,
    input logic [7:0] sp_out,
    input logic [7:0] status_out
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(write_data)
            && $stable(status_out) && $stable(acc_out))
    else $error("stalled result changed");

    // Write data is zero when no write is requested
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_enable |-> write_data == 8'd0)
    else $error("write data nonzero without write enable");

    // Status bit 5 reads one and B reads zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status_out[FLAG_ONE] && !status_out[FLAG_B])
    else $error("fixed status bits wrong");

    // A branch never writes memory
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(branch_taken && write_enable))
    else $error("branch with write enable");

    // The input side only stalls while holding an item that cannot move on
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

endmodule

bind cpu_6502_execute_unit cpu65_checker u_cpu65_checker (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import cpu65_pkg::*;

    // Codes with no entry in the package: the explicit NOP and the unused range
    localparam logic [6:0] OP_NOP          = 7'd64;
    localparam logic [6:0] OP_UNUSED_FIRST = 7'd65;
    localparam logic [6:0] OP_UNUSED_LAST  = 7'd127;

    localparam int IDLE_LIMIT   = 2000;  // cycles with no transfer on either side
    localparam int HOLD_CYCLES  = 64;    // long receiver hold-off
    localparam int HOLD_TRIGGER = 120;   // results checked before the hold-off starts
    localparam int DRAIN_CYCLES = 6;

    typedef enum logic [1:0] {SH_ASL, SH_LSR, SH_ROL, SH_ROR} shift_kind_t;

    typedef struct packed {
        logic [6:0] act;
        logic [7:0] opnd;
    } op_item_t;

    typedef struct packed {
        logic [7:0] wdata;
        logic       wen;
        logic       taken;
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] s;
        logic [7:0] p;
    } outcome_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [6:0] action = '0;
    logic [7:0] operand = '0;
    logic       out_valid;
    logic       out_stall = 1'b1;
    logic [7:0] write_data;
    logic       write_enable;
    logic       branch_taken;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] sp_out;
    logic [7:0] status_out;

    // Shadow register file of the execute unit
    logic [7:0] ra = 8'h00;
    logic [7:0] rx = 8'h00;
    logic [7:0] ry = 8'h00;
    logic [7:0] rs = SP_RESET;
    logic [7:0] rp = STATUS_RESET;

    op_item_t op_backlog[$];
    outcome_t outcome_q[$];
    outcome_t want;

    int send_idle_pct = 25;
    int recv_idle_pct = 59;
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_writes = 0;
    int n_taken = 0;
    int idle_run = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    cpu_6502_execute_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .operand      (operand),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_data   (write_data),
        .write_enable (write_enable),
        .branch_taken (branch_taken),
        .acc_out      (acc_out),
        .x_out        (x_out),
        .y_out        (y_out),
        .sp_out       (sp_out),
        .status_out   (status_out)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic logic [7:0] set_nz(logic [7:0] v);
        rp[FLAG_Z] = (v == 8'h00);
        rp[FLAG_N] = v[7];
        return v;
    endfunction

    // binary add into A with carry in; SBC passes the inverted operand
    function automatic void add_to_acc(logic [7:0] v);
        logic [8:0] sum;
        sum = {1'b0, ra} + {1'b0, v} + {8'h00, rp[FLAG_C]};
        rp[FLAG_C] = sum[8];
        rp[FLAG_V] = ~(ra[7] ^ v[7]) & (ra[7] ^ sum[7]);
        ra = set_nz(sum[7:0]);
    endfunction

    function automatic void compare_reg(logic [7:0] r, logic [7:0] v);
        rp[FLAG_C] = (r >= v);
        void'(set_nz(r - v));
    endfunction

    // shifter sets C from the bit shifted out, returns the result
    function automatic logic [7:0] shift_byte(shift_kind_t k, logic [7:0] v);
        logic       cin;
        logic [7:0] r;
        cin = rp[FLAG_C];
        case (k)
            SH_ASL:  begin r = {v[6:0], 1'b0}; rp[FLAG_C] = v[7]; end
            SH_LSR:  begin r = {1'b0, v[7:1]}; rp[FLAG_C] = v[0]; end
            SH_ROL:  begin r = {v[6:0], cin};  rp[FLAG_C] = v[7]; end
            default: begin r = {cin, v[7:1]};  rp[FLAG_C] = v[0]; end
        endcase
        return r;
    endfunction

    function automatic outcome_t execute_op(logic [6:0] act, logic [7:0] v);
        outcome_t   o;
        logic [7:0] wd;
        logic [7:0] m;
        logic       we;
        logic       br;
        wd = 8'h00;
        m  = 8'h00;
        we = 1'b0;
        br = 1'b0;
        case (act)
            OP_ADC:  add_to_acc(v);
            OP_SBC:  add_to_acc(~v);
            OP_AND:  ra = set_nz(ra & v);
            OP_ORA:  ra = set_nz(ra | v);
            OP_EOR:  ra = set_nz(ra ^ v);
            OP_ASLA: ra = set_nz(shift_byte(SH_ASL, ra));
            OP_LSRA: ra = set_nz(shift_byte(SH_LSR, ra));
            OP_ROLA: ra = set_nz(shift_byte(SH_ROL, ra));
            OP_RORA: ra = set_nz(shift_byte(SH_ROR, ra));
            OP_ASLM: begin wd = set_nz(shift_byte(SH_ASL, v)); we = 1'b1; end
            OP_LSRM: begin wd = set_nz(shift_byte(SH_LSR, v)); we = 1'b1; end
            OP_ROLM: begin wd = set_nz(shift_byte(SH_ROL, v)); we = 1'b1; end
            OP_RORM: begin wd = set_nz(shift_byte(SH_ROR, v)); we = 1'b1; end
            OP_INC:  begin wd = set_nz(v + 8'h01); we = 1'b1; end
            OP_DEC:  begin wd = set_nz(v - 8'h01); we = 1'b1; end
            OP_INX:  rx = set_nz(rx + 8'h01);
            OP_INY:  ry = set_nz(ry + 8'h01);
            OP_DEX:  rx = set_nz(rx - 8'h01);
            OP_DEY:  ry = set_nz(ry - 8'h01);
            OP_CMP:  compare_reg(ra, v);
            OP_CPX:  compare_reg(rx, v);
            OP_CPY:  compare_reg(ry, v);
            OP_BIT:
            begin
                rp[FLAG_Z] = ((ra & v) == 8'h00);
                rp[FLAG_N] = v[7];
                rp[FLAG_V] = v[6];
            end
            OP_LDA:  ra = set_nz(v);
            OP_LDX:  rx = set_nz(v);
            OP_LDY:  ry = set_nz(v);
            OP_STA:  begin wd = ra; we = 1'b1; end
            OP_STX:  begin wd = rx; we = 1'b1; end
            OP_STY:  begin wd = ry; we = 1'b1; end
            OP_TAX:  rx = set_nz(ra);
            OP_TAY:  ry = set_nz(ra);
            OP_TXA:  ra = set_nz(rx);
            OP_TYA:  ra = set_nz(ry);
            OP_TSX:  rx = set_nz(rs);
            OP_TXS:  rs = rx;
            OP_CLC:  rp[FLAG_C] = 1'b0;
            OP_SEC:  rp[FLAG_C] = 1'b1;
            OP_CLI:  rp[FLAG_I] = 1'b0;
            OP_SEI:  rp[FLAG_I] = 1'b1;
            OP_CLD:  rp[FLAG_D] = 1'b0;
            OP_SED:  rp[FLAG_D] = 1'b1;
            OP_CLV:  rp[FLAG_V] = 1'b0;
            OP_BCC:  br = ~rp[FLAG_C];
            OP_BCS:  br = rp[FLAG_C];
            OP_BEQ:  br = rp[FLAG_Z];
            OP_BNE:  br = ~rp[FLAG_Z];
            OP_BMI:  br = rp[FLAG_N];
            OP_BPL:  br = ~rp[FLAG_N];
            OP_BVC:  br = ~rp[FLAG_V];
            OP_BVS:  br = rp[FLAG_V];
            OP_ALR:  ra = set_nz(shift_byte(SH_LSR, ra & v));
            OP_ANC:
            begin
                ra = set_nz(ra & v);
                rp[FLAG_C] = rp[FLAG_N];
            end
            OP_ARR:
            begin
                ra = set_nz(shift_byte(SH_ROR, ra & v));
                rp[FLAG_C] = ra[6];
                rp[FLAG_V] = ra[6] ^ ra[5];
            end
            OP_AXS:
            begin
                m = ra & rx;
                rp[FLAG_C] = (m >= v);
                rx = set_nz(m - v);
            end
            OP_DCP:
            begin
                wd = v - 8'h01;
                we = 1'b1;
                compare_reg(ra, wd);
            end
            OP_ISC:
            begin
                wd = v + 8'h01;
                we = 1'b1;
                add_to_acc(~wd);
            end
            OP_LAS:
            begin
                rs = rs & v;
                ra = rs;
                rx = set_nz(rs);
            end
            OP_LAX:
            begin
                ra = v;
                rx = set_nz(v);
            end
            OP_RLA:
            begin
                wd = shift_byte(SH_ROL, v);
                we = 1'b1;
                ra = set_nz(ra & wd);
            end
            OP_RRA:
            begin
                wd = shift_byte(SH_ROR, v);
                we = 1'b1;
                add_to_acc(wd);
            end
            OP_SLO:
            begin
                wd = shift_byte(SH_ASL, v);
                we = 1'b1;
                ra = set_nz(ra | wd);
            end
            OP_SRE:
            begin
                wd = shift_byte(SH_LSR, v);
                we = 1'b1;
                ra = set_nz(ra ^ wd);
            end
            OP_SAX:  begin wd = ra & rx; we = 1'b1; end
            OP_XAA:  ra = set_nz(rx & v);
            default: ;  // NOP and unused codes
        endcase
        o.wdata = we ? wd : 8'h00;
        o.wen   = we;
        o.taken = br;
        o.a     = ra;
        o.x     = rx;
        o.y     = ry;
        o.s     = rs;
        o.p     = rp;
        o.p[FLAG_B]   = 1'b0;
        o.p[FLAG_ONE] = 1'b1;
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic queue_op(logic [6:0] act, logic [7:0] opnd);
        op_item_t it;
        it.act  = act;
        it.opnd = opnd;
        op_backlog.push_back(it);
    endtask

    // operand with extra weight on the corner values
    function automatic logic [7:0] pick_operand();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [6:0] pick_action();
        if ($urandom_range(99) < 6)
            return 7'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
        return 7'($urandom_range(OP_NOP, OP_ADC));
    endfunction

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            queue_op(pick_action(), pick_operand());
    endtask

    // ---------------------------------------------------------------
    // Driver: offers ops from the backlog, holds them while stalled
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        op_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action   <= '0;
            operand  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                outcome_q.push_back(execute_op(action, operand));
                n_sent++;
            end
            // a stalled transfer keeps its payload
            if (!(in_valid && in_stall))
            begin
                if (op_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = op_backlog.pop_front();
                    in_valid <= 1'b1;
                    action   <= nxt.act;
                    operand  <= nxt.opnd;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks each result transfer, drives the output stall
    // ---------------------------------------------------------------
    function automatic void check_field(string name, logic [7:0] got, logic [7:0] exp_v);
        if (got !== exp_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, exp_v, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b1;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (outcome_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result transfer with nothing expected", $time);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    n_checked++;
                    if (want.wen)
                        n_writes++;
                    if (want.taken)
                        n_taken++;
                    check_field("write_data", write_data, want.wdata);
                    check_field("write_enable", {7'b0, write_enable}, {7'b0, want.wen});
                    check_field("branch_taken", {7'b0, branch_taken}, {7'b0, want.taken});
                    check_field("acc_out", acc_out, want.a);
                    check_field("x_out", x_out, want.x);
                    check_field("y_out", y_out, want.y);
                    check_field("sp_out", sp_out, want.s);
                    check_field("status_out", status_out, want.p);
                end
            end
            // one long hold-off lets the pipeline fill and back up the input
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && n_checked >= HOLD_TRIGGER)
            begin
                out_stall <= 1'b1;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_run <= 0;
            else
                idle_run <= idle_run + 1;
            if (idle_run >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("FAIL cpu_6502_execute_unit");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence: reset, directed ops, then three random phases
    // ---------------------------------------------------------------
    initial
    begin
        // directed: reset state, unused codes, corner flags, undocumented ops
        queue_op(OP_NOP, 8'h00);
        queue_op(OP_UNUSED_LAST, 8'hFF);
        queue_op(OP_LDA, 8'h00);
        queue_op(OP_LDA, 8'h80);
        queue_op(OP_LDA, 8'h7F);
        queue_op(OP_CLC, 8'h00);
        queue_op(OP_ADC, 8'h01);        // signed overflow into 0x80
        queue_op(OP_SBC, 8'hFF);        // borrow in, carry out clear
        queue_op(OP_LDA, 8'hFF);
        queue_op(OP_LDX, 8'h0F);
        queue_op(OP_AXS, 8'h10);        // AXS with borrow
        queue_op(OP_AXS, 8'h00);        // AXS without borrow
        queue_op(OP_SEC, 8'h00);
        queue_op(OP_ARR, 8'hFF);        // ARR: C and V from result bits 6 and 5
        queue_op(OP_ARR, 8'h40);
        queue_op(OP_LDX, 8'hF0);
        queue_op(OP_XAA, 8'h55);        // XAA: A = X AND operand
        queue_op(OP_LAS, 8'h0F);        // LAS narrows S
        queue_op(OP_STA, 8'hFF);
        queue_op(OP_ASLM, 8'h80);
        queue_op(OP_BEQ, 8'h00);
        queue_op(OP_BMI, 8'h00);
        queue_op(OP_DEC, 8'h00);
        queue_op(OP_UNUSED_FIRST, 8'h00);
        // every defined code once, random operands
        for (int c = OP_ADC; c <= OP_NOP; c++)
            queue_op(7'(c), pick_operand());
        queue_random(150);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // sender heavier, receiver lighter idling
        while (op_backlog.size() != 0)
            @(negedge clk);
        send_idle_pct = 59;
        recv_idle_pct = 25;
        queue_random(200);

        // no idling on either side
        while (op_backlog.size() != 0)
            @(negedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(200);

        while (op_backlog.size() != 0 || in_valid)
            @(negedge clk);
        while (outcome_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Executed %0d ops (all codes, unused range included) under three flow phases",
                 n_sent);
        $display("Checked %0d results: %0d memory writes, %0d branches taken",
                 n_checked, n_writes, n_taken);
        if (errors == 0)
            $display("PASS cpu_6502_execute_unit");
        else
            $display("FAIL cpu_6502_execute_unit");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/cpu65_pkg.sv
rtl/core/cpu65_alu.sv
rtl/core/cpu_6502_execute_unit.sv
rtl/core/cpu65_checker.sv
verif/tb_top.sv
